/* sv/ess_pkg.sv */
package ess_pkg;

  localparam int MAX_LENGTH_DEF   = 4194304;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int CFG_W = 64;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_PHASE_SCALE = 3'd0;
  localparam logic [IDX_W-1:0] REG_GROWTH      = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHRINK      = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_LEVEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LENGTH      = 3'd4;
  localparam logic [IDX_W-1:0] REG_FADE_IN     = 3'd5;
  localparam logic [IDX_W-1:0] REG_FADE_OUT    = 3'd6;
  localparam logic [IDX_W-1:0] REG_INVERSE     = 3'd7;

  localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PHASE_MUL,  // one partial product of the phase product
    OP_PHASE,      // load cordic angle from the phase product
    OP_CORDIC,     // one cordic rotation
    OP_KEEP_SINE,  // latch sine as the sample value
    OP_DIV_START,  // start window angle divide (in or out)
    OP_DIV_STEP,   // one restoring divide bit
    OP_SQUARE,     // square window sine
    OP_APPLY_WIN,  // sample times window
    OP_APPLY_AMP,  // sample times decay amplitude
    OP_LVL_MUL,    // one partial product of level update
    OP_AMP_MUL,    // one partial product of amplitude update
    OP_FINISH      // round, saturate, load output and advance index
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PMUL, S_PHASE, S_CORDIC, S_SINE, S_WIN_SEL, S_DIV, S_WCORDIC, S_SQUARE,
    S_APPLY, S_AMP, S_LVL, S_AMPM, S_FINISH, S_WAIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic       win_out;   // 0 fade-in window, 1 fade-out window
    logic       restart;   // reload state before this request
    logic [1:0] part;      // partial product select
  } dp_cmd_t;

  typedef struct packed {
    logic need_in;
    logic need_out;
    logic inverse;
    logic last;
    logic step_done;   // divide sequence finished
  } dp_status_t;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};
    if (i < 32) return t[i];
    return 32'd0;
  endfunction

endpackage

/* sv/ess_ctrl.sv */
module ess_ctrl
  import ess_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_restart,
  input  logic       out_free,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic        win_out, win_out_next;
  logic        did_in, did_in_next;

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      win_out <= 1'b0;
      did_in  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      win_out <= win_out_next;
      did_in  <= did_in_next;
    end
  end

  // Sequence one request through the datapath
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    win_out_next = win_out;
    did_in_next  = did_in;
    in_stall     = 1'b1;
    cmd          = '{op: OP_NONE, win_out: win_out, restart: 1'b0, part: cnt[1:0]};
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.restart = in_restart;
          cnt_next    = '0;
          state_next  = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd.op   = OP_PHASE_MUL;
        cnt_next = cnt + 6'd1;
        if (cnt[1:0] == 2'd3) begin
          cnt_next   = '0;
          state_next = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.op     = OP_PHASE;
        cnt_next   = '0;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op   = OP_CORDIC;
        cmd.part = 2'd0;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(CORDIC_STEPS - 1)) state_next = S_SINE;
      end
      S_SINE: begin
        cmd.op      = OP_KEEP_SINE;
        did_in_next = 1'b0;
        state_next  = status.inverse ? S_AMP : S_WIN_SEL;
      end
      S_WIN_SEL: begin
        priority if (!did_in && status.need_in) begin
          win_out_next = 1'b0;
          cmd.win_out  = 1'b0;
          cmd.op       = OP_DIV_START;
          did_in_next  = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else if (!win_out && status.need_out) begin
          win_out_next = 1'b1;
          cmd.win_out  = 1'b1;
          cmd.op       = OP_DIV_START;
          did_in_next  = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          win_out_next = 1'b0;
          cnt_next     = '0;
          state_next   = S_LVL;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.step_done) begin
          cnt_next   = '0;
          state_next = S_WCORDIC;
        end
      end
      S_WCORDIC: begin
        cmd.op   = OP_CORDIC;
        cmd.part = 2'd1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(CORDIC_STEPS - 1)) state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.op     = OP_SQUARE;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.op     = OP_APPLY_WIN;
        // after fade-out nothing is left; after fade-in try fade-out
        if (win_out) begin
          win_out_next = 1'b0;
          cnt_next     = '0;
          state_next   = S_LVL;
        end else begin
          win_out_next = 1'b1;
          state_next   = status.need_out ? S_WIN_SEL : S_LVL;
          win_out_next = 1'b0;
          if (status.need_out) begin
            // mark fade-in as done, pick fade-out next
            did_in_next = 1'b1;
          end
          cnt_next = '0;
        end
      end
      S_AMP: begin
        cmd.op     = OP_APPLY_AMP;
        cnt_next   = '0;
        state_next = S_LVL;
      end
      S_LVL: begin
        cmd.op   = OP_LVL_MUL;
        cnt_next = cnt + 6'd1;
        if (cnt[1:0] == 2'd3) begin
          cnt_next   = '0;
          state_next = S_AMPM;
        end
      end
      S_AMPM: begin
        cmd.op   = OP_AMP_MUL;
        cnt_next = cnt + 6'd1;
        if (cnt[1:0] == 2'd3) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/ess_datapath.sv */
module ess_datapath
  import ess_pkg::*;
#(
  parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_free,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last_sample
);

  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int SW = $clog2(CORDIC_STEPS + 1);

  // configuration
  logic [47:0] phase_scale;
  logic [62:0] growth, shrink;
  logic [63:0] end_level;
  logic [22:0] sweep_length, fade_in_count, fade_out_count;
  logic        inverse_mode;

  // sweep state
  logic [LW-1:0] sample_index;
  logic [63:0]   level, decay_amplitude;

  // working registers
  logic [LW-1:0]       eff, fi, fo, back;
  logic                last;
  logic signed [33:0]  cx, cy;
  logic signed [34:0]  cz;
  logic [SW-1:0]       step;
  logic signed [33:0]  sval, wsine;
  logic [63:0]         acc_lo, acc_hi;
  logic [63:0]         level_new;
  logic [31:0]         quo;
  logic [LW+30:0]      rem;
  logic [5:0]          dcnt;
  logic [LW-1:0]       divisor;

  // Clamp length and derive sample position
  logic [LW-1:0] n_c, idx_c;
  logic [23:0]   len_w;
  always_comb begin
    len_w = {1'b0, sweep_length};
    if (len_w == 24'd0) len_w = 24'd1;
    if (32'(len_w) > 32'(MAX_LENGTH)) n_c = LW'(MAX_LENGTH);
    else n_c = LW'(len_w);
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_scale    <= '0;
      growth         <= ONE_Q62[62:0];
      shrink         <= ONE_Q62[62:0];
      end_level      <= ONE_Q40;
      sweep_length   <= 23'd1;
      fade_in_count  <= '0;
      fade_out_count <= '0;
      inverse_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_SCALE: phase_scale    <= cfg_data[47:0];
        REG_GROWTH:      growth         <= cfg_data[62:0];
        REG_SHRINK:      shrink         <= cfg_data[62:0];
        REG_END_LEVEL:   end_level      <= cfg_data;
        REG_LENGTH:      sweep_length   <= cfg_data[22:0];
        REG_FADE_IN:     fade_in_count  <= cfg_data[22:0];
        REG_FADE_OUT:    fade_out_count <= cfg_data[22:0];
        REG_INVERSE:     inverse_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // cordic step arithmetic
  logic signed [33:0] dx, dy;
  logic signed [34:0] at;
  always_comb begin
    dx = cy >>> step;
    dy = cx >>> step;
    at = 35'(atan_turns(int'(step)));
  end

  // 32x32 partial product shared by the phase, level and amplitude products
  logic [63:0] ma, mb;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] full;
  always_comb begin
    if (cmd.op == OP_PHASE_MUL) begin
      ma = {16'd0, phase_scale};
      mb = level - ONE_Q40;
    end else if (cmd.op == OP_LVL_MUL) begin
      ma = level;
      mb = inverse_mode ? {1'b0, shrink} : {1'b0, growth};
    end else begin
      ma = decay_amplitude;
      mb = {1'b0, shrink};
    end
    pa = cmd.part[0] ? ma[63:32] : ma[31:0];
    pb = cmd.part[1] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    full = {acc_hi, acc_lo};
  end

  // Accumulated product shifted by 62, rounded and saturated
  function automatic logic [63:0] q62_result(input logic [127:0] f);
    logic [64:0] r;
    if (f[127:126] != 2'b00) return '1;
    r = {1'b0, f[125:62]} + 65'(f[61]);
    if (r[64]) return '1;
    return r[63:0];
  endfunction

  // signed product helpers
  logic signed [67:0] sprod;
  logic signed [33:0] sa, sb;
  always_comb begin
    sa = sval;
    unique case (cmd.op)
      OP_SQUARE:    begin sa = yc; sb = yc; end
      OP_APPLY_WIN: sb = wsine;
      OP_APPLY_AMP: sb = 34'($signed({1'b0, decay_amplitude[63:32]}));
      default:      sb = sval;
    endcase
    sprod = sa * sb;
  end

  function automatic logic signed [33:0] rnd30(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = (v + 68'sd536870912) >>> 30;
    return t[33:0];
  endfunction

  // clamp cordic output
  logic signed [33:0] yc;
  always_comb begin
    yc = cy;
    if (cy > ONE_Q30) yc = ONE_Q30;
    if (cy < -ONE_Q30) yc = -ONE_Q30;
  end

  // angle fold for cordic
  function automatic logic signed [34:0] fold(input logic [31:0] t);
    logic signed [34:0] p;
    p = 35'($signed(t));
    if (p > 35'sd1073741824) p = 35'sd2147483648 - p;
    else if (p < -35'sd1073741824) p = -35'sd2147483648 - p;
    return p;
  endfunction

  // Output rounding and saturation
  localparam int FRAC = SAMPLE_BITS - 1;
  logic signed [SAMPLE_BITS-1:0] sat_v;
  logic signed [63:0] ov, lim;
  always_comb begin
    if (FRAC <= 30) ov = 64'($signed(sval + 34'(((35'sd1) <<< (30 - FRAC)) >>> 1)))
                        >>> (30 - FRAC);
    else ov = 64'(sval) <<< (FRAC - 30);
    if (FRAC == 30) ov = 64'(sval);
    lim = (64'sd1 <<< FRAC) - 64'sd1;
    if (ov > lim) ov = lim;
    if (ov < -lim) ov = -lim;
    sat_v = ov[SAMPLE_BITS-1:0];
  end

  logic [LW-1:0] eff_c;
  always_comb begin
    idx_c = (sample_index < n_c) ? sample_index : n_c - LW'(1);
    eff_c = idx_c;
  end

  // Run datapath operations
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      level           <= ONE_Q40;
      decay_amplitude <= ONE_Q62;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.restart) begin
        sample_index    <= '0;
        level           <= inverse_mode ? end_level : ONE_Q40;
        decay_amplitude <= ONE_Q62;
      end
      unique case (cmd.op)
        OP_FINISH: begin
          out_valid   <= 1'b1;
          sample_out  <= sat_v;
          last_sample <= last;
          if (last) begin
            sample_index    <= '0;
            level           <= inverse_mode ? end_level : ONE_Q40;
            decay_amplitude <= ONE_Q62;
          end else begin
            sample_index    <= eff + LW'(1);
            level           <= level_new;
            decay_amplitude <= q62_result(full);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb out_free = !out_valid || !out_stall;

  // Payload work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PHASE: begin
        eff   <= eff_c;
        last  <= (eff_c == n_c - LW'(1));
        fi    <= ({1'b0, fade_in_count} < 24'(n_c)) ? LW'(fade_in_count) : n_c;
        fo    <= ({1'b0, fade_out_count} < 24'(n_c)) ? LW'(fade_out_count) : n_c;
        back  <= n_c - LW'(1) - eff_c;
        cx    <= CORDIC_GAIN;
        cy    <= '0;
        step  <= '0;
        // top 32 bits of the wrapped 64-bit phase product
        cz    <= fold(full[63:32]);
      end
      OP_CORDIC: begin
        if (cz >= 0) begin
          cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
        end else begin
          cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
        end
        step <= step + SW'(1);
      end
      OP_KEEP_SINE: sval <= yc;
      OP_DIV_START: begin
        divisor <= cmd.win_out ? fo : fi;
        rem     <= '0;
        quo     <= '0;
        dcnt    <= '0;
      end
      OP_DIV_STEP: begin
        // restoring divide of (j << 30) by the fade count, one bit a cycle
        logic [LW+30:0] num, r2;
        num = (LW+31)'(cmd.win_out ? back : eff) << 30;
        r2  = {rem[LW+29:0], num[LW+30 - 6'(dcnt)]};
        if (r2 >= (LW+31)'(divisor)) begin
          rem <= r2 - (LW+31)'(divisor);
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= r2;
          quo <= {quo[30:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'(LW + 30)) begin
          cx   <= CORDIC_GAIN;
          cy   <= '0;
          step <= '0;
          cz   <= fold((r2 >= (LW+31)'(divisor)) ? {quo[30:0], 1'b1} : {quo[30:0], 1'b0});
        end
      end
      OP_SQUARE:    wsine <= rnd30(sprod);
      OP_APPLY_WIN: sval  <= rnd30(sprod);
      OP_APPLY_AMP: sval  <= rnd30(sprod);
      OP_PHASE_MUL, OP_LVL_MUL, OP_AMP_MUL: begin
        logic [127:0] sum;
        sum = ((cmd.part == 2'd0) ? 128'd0 : full)
            + (128'(pp) << (32 * (int'(cmd.part[0]) + int'(cmd.part[1]))));
        {acc_hi, acc_lo} <= sum;
        if (cmd.op == OP_AMP_MUL && cmd.part == 2'd0) level_new <= q62_result(full);
      end
      default: ;
    endcase
  end

  // Status toward the controller
  always_comb begin
    status.need_in   = (eff < fi);
    status.need_out  = (back < fo);
    status.inverse   = inverse_mode;
    status.last      = last;
    status.step_done = (cmd.op == OP_DIV_STEP) && (dcnt == 6'(LW + 30));
  end

endmodule

/* sv/exp_sine_sweep_generator.sv */
// Exponential sine sweep generator.
// Each request on the input channel (valid/stall, field restart) yields one
// sample on the output channel (sample_out, last_sample). restart=1 starts
// again at sample zero; restart=0 advances one sample. After the final sample
// (last_sample=1) the sweep wraps to sample zero by itself.
// Configuration is written through cfg_we/cfg_index/cfg_data while no request
// is in flight; level and mode changes take effect at restart or wrap.
// One request at a time: with no fade window applied (inverse mode, or a
// sample outside both fades) a request runs the phase product, one CORDIC
// pass and the level and amplitude update. Each applied fade window adds a
// bit-serial angle divide, a second CORDIC pass, a square and a window
// multiply; a fade-out after a fade-in adds another pass through window select.
// The next request is taken in the cycle after the result is loaded into the
// output register. When the receiver stalls, the finished result holds and
// the next request waits before its final step. Synchronous reset clears the
// sweep to sample zero and loads the register defaults.
module exp_sine_sweep_generator
  import ess_pkg::*;
#(
  parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last_sample
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       out_free;

  ess_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_restart(restart),
    .out_free, .status, .cmd
  );

  ess_datapath #(
    .MAX_LENGTH(MAX_LENGTH), .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd, .status,
    .out_valid, .out_stall, .out_free, .sample_out, .last_sample
  );

endmodule
